// ----- rtl/rc5bd_pkg.sv -----
// Shared types, constants and rotate helpers for the RC5-32 block decryptor.
package rc5bd_pkg;

  localparam logic [31:0] PQ_START  = 32'hb7e15163;
  localparam logic [31:0] PQ_STEP   = 32'h9e3779b9;
  localparam int          KEY_WORDS = 4;
  localparam int          KEY_BYTES_HW = 16;
  localparam int          MIX_PASSES = 3;

  typedef enum logic [1:0] {
    REG_ROUND_COUNT = 2'd0,
    REG_KEY_LENGTH  = 2'd1,
    REG_KEY_LOW     = 2'd2,
    REG_KEY_HIGH    = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MIX_RD,
    ST_MIX_A,
    ST_MIX_B,
    ST_DEC,
    ST_DEC_END,
    ST_DONE
  } core_state_e;

  typedef struct packed {
    logic [5:0]  round_count;
    logic [4:0]  key_length;
    logic [63:0] key_bytes_low;
    logic [63:0] key_bytes_high;
  } cfg_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

endpackage

// ----- rtl/rc5_block_decryptor.sv -----
// RC5-32 block decryptor top level: APB registers, key table memory and sequencer.
// Decrypt (R = keyed rounds): one table word read and one half-round per cycle through the
//   single memory port; ST_DEC_END and ST_DONE then load the result register.
// Key schedule: 2R+2 fill writes, then 3*(2R+2) mix steps, each an ST_MIX_A and an ST_MIX_B state.
// One item in flight; the next is taken the cycle after the result enters the output register.
// Async active-low reset clears control and the keyed flag, sets 12 rounds and 16 key bytes.
module rc5_block_decryptor #(
  parameter int MAX_ROUNDS    = 32,
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] cipher_word0, [63:32] cipher_word1
  input  logic        s_axis_tuser,   // [0] action
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] plain_word0, [63:32] plain_word1
  output logic        m_axis_tuser,   // [0] not_keyed
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import rc5bd_pkg::*;

  localparam int TABLE_DEPTH = 2 * MAX_ROUNDS + 2;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int RW = $clog2(MAX_ROUNDS + 1);

  cfg_t          cfg;
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;

  rc5bd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rc5bd_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  rc5bd_core #(
    .MAX_ROUNDS    (MAX_ROUNDS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .RW            (RW),
    .IW            (IW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_w0_i     (s_axis_tdata[31:0]),
    .in_w1_i     (s_axis_tdata[63:32]),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_w0_o    (m_axis_tdata[31:0]),
    .out_w1_o    (m_axis_tdata[63:32]),
    .out_nk_o    (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

endmodule

// ----- rtl/rc5bd_regs.sv -----
// APB configuration registers: round count, key length and key bytes.
module rc5bd_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output rc5bd_pkg::cfg_t    cfg_o
);
  import rc5bd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:3]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ROUND_COUNT: cfg_d.round_count    = pwdata[5:0];
        REG_KEY_LENGTH:  cfg_d.key_length     = pwdata[4:0];
        REG_KEY_LOW:     cfg_d.key_bytes_low  = pwdata;
        REG_KEY_HIGH:    cfg_d.key_bytes_high = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROUND_COUNT: prdata = {58'd0, cfg_q.round_count};
      REG_KEY_LENGTH:  prdata = {59'd0, cfg_q.key_length};
      REG_KEY_LOW:     prdata = cfg_q.key_bytes_low;
      REG_KEY_HIGH:    prdata = cfg_q.key_bytes_high;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.round_count    <= 6'd12;
      cfg_q.key_length     <= 5'd16;
      cfg_q.key_bytes_low  <= '0;
      cfg_q.key_bytes_high <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/rc5bd_ram.sv -----
// Single-port round-key table memory with registered read data.
module rc5bd_ram #(
  parameter int DEPTH = 66,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [31:0]   wdata_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rc5bd_core.sv -----
// Sequencer and datapath: key table fill and mix, half-round decryption, result register.
module rc5bd_core #(
  parameter int MAX_ROUNDS    = 32,
  parameter int MAX_KEY_BYTES = 16,
  parameter int RW            = 6,
  parameter int IW            = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rc5bd_pkg::cfg_t    cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_action_i,
  input  logic [31:0]        in_w0_i,
  input  logic [31:0]        in_w1_i,
  input  logic               in_last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        out_w0_o,
  output logic [31:0]        out_w1_o,
  output logic               out_nk_o,
  output logic               out_last_o,
  output logic               mem_we_o,
  output logic [IW-1:0]      mem_addr_o,
  output logic [31:0]        mem_wdata_o,
  input  logic [31:0]        mem_rdata_i
);
  import rc5bd_pkg::*;

  localparam int KLIM = (MAX_KEY_BYTES > KEY_BYTES_HW) ? KEY_BYTES_HW : MAX_KEY_BYTES;

  core_state_e state_q, state_d;

  logic                          keyed_q, keyed_d;
  logic [RW-1:0]                 rounds_q, rounds_d;
  logic [KEY_WORDS-1:0][31:0]    key_q, key_d;
  logic [1:0]                    kwl_q, kwl_d;
  logic [IW-1:0]                 ti_q, ti_d;
  logic [IW-1:0]                 raddr_q, raddr_d;
  logic                          pend_q, pend_d;
  logic [1:0]                    ki_q, ki_d;
  logic [1:0]                    pass_q, pass_d;
  logic [31:0]                   fill_q, fill_d;
  logic [31:0]                   a_q, a_d, b_q, b_d;
  logic [31:0]                   d0_q, d0_d, d1_q, d1_d;
  logic                          nk_q, nk_d, last_q, last_d;
  logic                          ov_q, ov_d;
  logic [31:0]                   ow0_q, ow0_d, ow1_q, ow1_d;
  logic                          onk_q, onk_d, olast_q, olast_d;

  logic [RW-1:0]  rounds_c;
  logic [4:0]     klen_c;
  logic [4:0]     kbytes_c;
  logic [127:0]   kb_c;
  logic [IW-1:0]  tlast;
  logic [IW-1:0]  ti_next;
  logic [31:0]    sum_ab, base;
  logic           full_rnd;

  // Clamp configured round count and key length, and zero key bytes past the key length.
  always_comb begin
    if (cfg_i.round_count == '0) begin
      rounds_c = RW'(1);
    end else if (int'(cfg_i.round_count) > MAX_ROUNDS) begin
      rounds_c = RW'(MAX_ROUNDS);
    end else begin
      rounds_c = RW'(cfg_i.round_count);
    end
    if (cfg_i.key_length == '0) begin
      klen_c = 5'd1;
    end else if (int'(cfg_i.key_length) > KLIM) begin
      klen_c = 5'(KLIM);
    end else begin
      klen_c = cfg_i.key_length;
    end
    kbytes_c = klen_c + 5'd3;
    kb_c = {cfg_i.key_bytes_high, cfg_i.key_bytes_low};
    for (int i = 0; i < KEY_BYTES_HW; i++) begin
      if (5'(i) >= klen_c) begin
        kb_c[8*i +: 8] = 8'd0;
      end
    end
  end

  assign tlast   = IW'({rounds_q, 1'b1});
  assign ti_next = (ti_q == tlast) ? '0 : ti_q + IW'(1);
  assign sum_ab  = a_q + b_q;
  assign full_rnd = |raddr_q[IW-1:1];

  always_comb begin
    state_d = state_q;
    keyed_d = keyed_q;
    rounds_d = rounds_q;
    key_d = key_q;
    kwl_d = kwl_q;
    ti_d = ti_q;
    raddr_d = raddr_q;
    pend_d = pend_q;
    ki_d = ki_q;
    pass_d = pass_q;
    fill_d = fill_q;
    a_d = a_q;
    b_d = b_q;
    d0_d = d0_q;
    d1_d = d1_q;
    nk_d = nk_q;
    last_d = last_q;
    ov_d = ov_q & ~out_ready_i;
    ow0_d = ow0_q;
    ow1_d = ow1_q;
    onk_d = onk_q;
    olast_d = olast_q;
    mem_we_o = 1'b0;
    mem_addr_o = ti_q;
    mem_wdata_o = a_q;
    in_ready_o = 1'b0;
    base = '0;

    // Consume the table word read in the previous cycle (decrypt half-round).
    if ((state_q == ST_DEC || state_q == ST_DEC_END) && pend_q) begin
      if (raddr_q[0]) begin
        base = d1_q - mem_rdata_i;
        d1_d = full_rnd ? (rotr32(base, d0_q[4:0]) ^ d0_q) : base;
      end else begin
        base = d0_q - mem_rdata_i;
        d0_d = full_rnd ? (rotr32(base, d1_q[4:0]) ^ d1_q) : base;
      end
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          last_d = in_last_i;
          nk_d   = 1'b0;
          d0_d   = '0;
          d1_d   = '0;
          if (!in_action_i) begin
            rounds_d = rounds_c;
            key_d    = kb_c;
            kwl_d    = kbytes_c[3:2] - 2'd1;
            ti_d     = '0;
            ki_d     = '0;
            pass_d   = '0;
            fill_d   = PQ_START;
            a_d      = '0;
            b_d      = '0;
            state_d  = ST_FILL;
          end else if (!keyed_q) begin
            nk_d    = 1'b1;
            state_d = ST_DONE;
          end else begin
            d0_d    = in_w0_i;
            d1_d    = in_w1_i;
            ti_d    = tlast;
            pend_d  = 1'b0;
            state_d = ST_DEC;
          end
        end
      end
      ST_FILL: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = fill_q;
        fill_d      = fill_q + PQ_STEP;
        ti_d        = ti_next;
        if (ti_q == tlast) begin
          state_d = ST_MIX_RD;
        end
      end
      ST_MIX_RD: begin
        state_d = ST_MIX_A;
      end
      ST_MIX_A: begin
        a_d         = rotl32(mem_rdata_i + a_q + b_q, 5'd3);
        mem_we_o    = 1'b1;
        mem_wdata_o = a_d;
        state_d     = ST_MIX_B;
      end
      ST_MIX_B: begin
        b_d        = rotl32(key_q[ki_q] + sum_ab, sum_ab[4:0]);
        key_d[ki_q] = b_d;
        ki_d       = (ki_q == kwl_q) ? 2'd0 : ki_q + 2'd1;
        ti_d       = ti_next;
        // Issue the read for the next step now; it never hits the entry just written.
        mem_addr_o = ti_next;
        if (ti_q == tlast) begin
          pass_d = pass_q + 2'd1;
        end
        if (ti_q == tlast && pass_q == 2'(MIX_PASSES - 1)) begin
          keyed_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_MIX_A;
        end
      end
      ST_DEC: begin
        pend_d  = 1'b1;
        raddr_d = ti_q;
        if (ti_q == '0) begin
          state_d = ST_DEC_END;
        end else begin
          ti_d = ti_q - IW'(1);
        end
      end
      ST_DEC_END: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ow0_d   = d0_q;
          ow1_d   = d1_q;
          onk_d   = nk_q;
          olast_d = last_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyed_q <= 1'b0;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      keyed_q <= keyed_d;
      ov_q    <= ov_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rounds_q <= rounds_d;
    key_q    <= key_d;
    kwl_q    <= kwl_d;
    ti_q     <= ti_d;
    raddr_q  <= raddr_d;
    ki_q     <= ki_d;
    pass_q   <= pass_d;
    fill_q   <= fill_d;
    a_q      <= a_d;
    b_q      <= b_d;
    d0_q     <= d0_d;
    d1_q     <= d1_d;
    nk_q     <= nk_d;
    last_q   <= last_d;
    ow0_q    <= ow0_d;
    ow1_q    <= ow1_d;
    onk_q    <= onk_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o = ov_q;
  assign out_w0_o    = ow0_q;
  assign out_w1_o    = ow1_q;
  assign out_nk_o    = onk_q;
  assign out_last_o  = olast_q;

endmodule

// ----- rtl/rc5bd_checker.sv -----
// Port-level checks for the RC5 block decryptor, bound to the top level.
module rc5bd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // One item at a time: the input side closes right after a transfer.
  a_in_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  // An unkeyed decrypt reports zeros.
  a_not_keyed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("not_keyed result carries nonzero data");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed or dropped");

  // A result only leaves through a transfer.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result withdrawn without transfer");

endmodule

bind rc5_block_decryptor rc5bd_checker u_rc5bd_checker (.*);

// ----- bench/rc5_block_decryptor_tb.sv -----
// Self-checking bench for the RC5-32 block decryptor: key schedules and block decrypts.
module rc5_block_decryptor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rc5bd_pkg::*;

  localparam int          MAX_RND      = 32;
  localparam int          MAX_KEYB     = 16;
  localparam int          TABLE_DEPTH  = 2 * MAX_RND + 2;
  localparam int          TOTAL_ITEMS  = 700;
  localparam int          CYCLE_LIMIT  = 2_000_000;
  localparam int          SETTLE_CYC   = 16;
  localparam logic        ACT_KEY      = 1'b0;
  localparam logic        ACT_DECRYPT  = 1'b1;

  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic        not_keyed;
    logic        last;
  } plain_exp_t;

  // Tracks the key table and round count the block should hold, and the plaintexts due.
  class plain_tracker;
    cfg_t         cfg;
    logic [31:0]  sched [TABLE_DEPTH];
    bit           keyed;
    int unsigned  keyed_rounds;
    plain_exp_t   plain_due [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  schedules;
    int unsigned  unkeyed_hits;

    function new();
      cfg.round_count    = 6'd12;
      cfg.key_length     = 5'd16;
      cfg.key_bytes_low  = '0;
      cfg.key_bytes_high = '0;
      keyed        = 1'b0;
      keyed_rounds = 0;
      mismatches   = 0;
      checked      = 0;
      schedules    = 0;
      unkeyed_hits = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [63:0] value);
      case (idx)
        REG_ROUND_COUNT: cfg.round_count    = value[5:0];
        REG_KEY_LENGTH:  cfg.key_length     = value[4:0];
        REG_KEY_LOW:     cfg.key_bytes_low  = value;
        REG_KEY_HIGH:    cfg.key_bytes_high = value;
        default: ;
      endcase
    endfunction

    function logic [31:0] rol32(logic [31:0] x, logic [31:0] n);
      int unsigned sh;
      sh = 32'(n[4:0]);
      if (sh == 0) return x;
      return (x << sh) | (x >> (32 - sh));
    endfunction

    function logic [31:0] ror32(logic [31:0] x, logic [31:0] n);
      int unsigned sh;
      sh = 32'(n[4:0]);
      if (sh == 0) return x;
      return (x >> sh) | (x << (32 - sh));
    endfunction

    function void expand_schedule();
      int unsigned rounds, klen, tlen, kwords, steps, ti, ki;
      logic [31:0] kw [4];
      logic [31:0] a, b;
      logic [7:0]  kbyte;
      rounds = 32'(cfg.round_count);
      if (rounds < 1) rounds = 1;
      if (rounds > MAX_RND) rounds = MAX_RND;
      klen = 32'(cfg.key_length);
      if (klen < 1) klen = 1;
      if (klen > 16) klen = 16;
      tlen   = 2 * rounds + 2;
      kwords = (klen + 3) / 4;
      for (int i = 0; i < 4; i++) kw[i] = '0;
      for (int i = 0; i < klen; i++) begin
        kbyte = (i < 8) ? cfg.key_bytes_low[8*i +: 8] : cfg.key_bytes_high[8*(i-8) +: 8];
        kw[i >> 2][8*(i & 3) +: 8] = kbyte;
      end
      sched[0] = PQ_START;
      for (int i = 1; i < tlen; i++) sched[i] = sched[i-1] + PQ_STEP;
      steps = 3 * ((kwords > tlen) ? kwords : tlen);
      a = '0;
      b = '0;
      ti = 0;
      ki = 0;
      for (int i = 0; i < steps; i++) begin
        a = rol32(sched[ti] + a + b, 32'd3);
        sched[ti] = a;
        b = rol32(kw[ki] + a + b, a + b);
        kw[ki] = b;
        ti = (ti + 1 == tlen) ? 0 : ti + 1;
        ki = (ki + 1 == kwords) ? 0 : ki + 1;
      end
      keyed_rounds = rounds;
      keyed = 1'b1;
    endfunction

    function logic [63:0] decrypt_block(logic [31:0] w0, logic [31:0] w1);
      logic [31:0] d0, d1;
      d0 = w0;
      d1 = w1;
      for (int r = keyed_rounds; r > 0; r--) begin
        d1 = ror32(d1 - sched[2*r+1], d0) ^ d0;
        d0 = ror32(d0 - sched[2*r], d1) ^ d1;
      end
      d0 = d0 - sched[0];
      d1 = d1 - sched[1];
      return {d1, d0};
    endfunction

    function void note_cipher(logic action, logic [31:0] w0, logic [31:0] w1, logic last);
      plain_exp_t e;
      e = '{word0: '0, word1: '0, not_keyed: 1'b0, last: last};
      if (action == ACT_KEY) begin
        expand_schedule();
        schedules++;
      end else if (!keyed) begin
        e.not_keyed = 1'b1;
        unkeyed_hits++;
      end else begin
        {e.word1, e.word0} = decrypt_block(w0, w1);
      end
      plain_due.push_back(e);
    endfunction

    function void check_plain(logic [31:0] w0, logic [31:0] w1, logic nk, logic last);
      plain_exp_t e;
      checked++;
      if (plain_due.size() == 0) begin
        $error("result transfer with nothing pending: word1 %h word0 %h", w1, w0);
        mismatches++;
        return;
      end
      e = plain_due.pop_front();
      if (w0 !== e.word0) begin
        $error("plain_word0 mismatch: expected %h, actual %h", e.word0, w0);
        mismatches++;
      end
      if (w1 !== e.word1) begin
        $error("plain_word1 mismatch: expected %h, actual %h", e.word1, w1);
        mismatches++;
      end
      if (nk !== e.not_keyed) begin
        $error("not_keyed mismatch: expected %b, actual %b", e.not_keyed, nk);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("last_out mismatch: expected %b, actual %b", e.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return plain_due.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // [31:0] cipher_word0, [63:32] cipher_word1
  logic        s_axis_tuser  = 1'b0; // [0] action
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // [31:0] plain_word0, [63:32] plain_word1
  logic        m_axis_tuser;         // [0] not_keyed
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [63:0] pwdata        = '0;
  logic [63:0] prdata;
  logic        pready;

  plain_tracker plain = new();
  bit           idle_on = 1'b1;
  int unsigned  sent_items = 0;
  int unsigned  reg_writes = 0;

  rc5_block_decryptor #(
    .MAX_ROUNDS   (MAX_RND),
    .MAX_KEY_BYTES(MAX_KEYB)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      plain.check_plain(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser, m_axis_tlast);
  end

  // Stall the result side in random bursts while idling is enabled.
  initial begin : sink_pacing
    bit hold_low;
    int burst;
    hold_low = 1'b0;
    burst    = 0;
    forever begin
      @(negedge clk_i);
      if (burst == 0) begin
        hold_low = ($urandom_range(0, 2) == 0);
        burst    = $urandom_range(1, 16);
      end
      burst--;
      m_axis_tready <= !(idle_on && hold_low);
    end
  end

  // Entered and left at a falling edge.
  task automatic apb_write(reg_idx_e idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    plain.write_reg(idx, value);
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Entered and left at a falling edge; valid stays high for a following item.
  task automatic send_item(logic action, logic [31:0] w0, logic [31:0] w1, logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w1, w0};
    s_axis_tuser  <= action;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    plain.note_cipher(action, w0, w1, last);
    sent_items++;
    @(negedge clk_i);
  endtask

  // Drop valid, drain every pending result, then let the sequencer settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (plain.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_config();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      apb_write(REG_ROUND_COUNT, 64'd0);
    else if (pick == 1)
      apb_write(REG_ROUND_COUNT, 64'($urandom_range(32, 63)));
    else
      apb_write(REG_ROUND_COUNT, 64'($urandom_range(1, 20)));
    if ($urandom_range(0, 1)) apb_write(REG_KEY_LENGTH, 64'($urandom_range(0, 31)));
    if ($urandom_range(0, 1)) apb_write(REG_KEY_LOW, {$urandom, $urandom});
    if ($urandom_range(0, 1)) apb_write(REG_KEY_HIGH, {$urandom, $urandom});
  endtask

  initial begin : main_seq
    int  len;
    logic act;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Decrypt before any schedule: flag set, zero data.
    send_item(ACT_DECRYPT, 32'h0, 32'h0, 1'b1);
    send_item(ACT_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    // Reset configuration, all-zero key.
    send_item(ACT_KEY, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_item(ACT_DECRYPT, 32'h0, 32'h0, 1'b0);
    send_item(ACT_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_item(ACT_DECRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0);
    wait_idle();

    // Zero round count and zero key length clamp to one.
    apb_write(REG_ROUND_COUNT, 64'd0);
    apb_write(REG_KEY_LENGTH, 64'd0);
    apb_write(REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
    apb_write(REG_KEY_HIGH, 64'h0);
    send_item(ACT_KEY, $urandom, $urandom, 1'b0);
    send_item(ACT_DECRYPT, $urandom, $urandom, 1'b0);
    send_item(ACT_DECRYPT, 32'h0, 32'hffff_ffff, 1'b1);
    wait_idle();

    // Largest legal round count and key length.
    apb_write(REG_ROUND_COUNT, 64'd32);
    apb_write(REG_KEY_LENGTH, 64'd16);
    apb_write(REG_KEY_LOW, {$urandom, $urandom});
    apb_write(REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
    send_item(ACT_KEY, 32'h0, 32'h0, 1'b1);
    send_item(ACT_DECRYPT, $urandom, $urandom, 1'b0);
    send_item(ACT_DECRYPT, 32'hffff_ffff, 32'h0, 1'b1);
    wait_idle();

    // Register values past the maxima saturate.
    apb_write(REG_ROUND_COUNT, 64'd63);
    apb_write(REG_KEY_LENGTH, 64'd31);
    send_item(ACT_KEY, $urandom, $urandom, 1'b0);
    send_item(ACT_DECRYPT, $urandom, $urandom, 1'b1);
    wait_idle();

    // Reconfigure without rekeying: decrypts keep the latched schedule until a key action.
    apb_write(REG_ROUND_COUNT, 64'd1);
    apb_write(REG_KEY_LENGTH, 64'd5);
    apb_write(REG_KEY_LOW, {$urandom, $urandom});
    apb_write(REG_KEY_HIGH, {$urandom, $urandom});
    send_item(ACT_DECRYPT, $urandom, $urandom, 1'b0);
    send_item(ACT_DECRYPT, $urandom, $urandom, 1'b1);
    send_item(ACT_KEY, $urandom, $urandom, 1'b0);
    send_item(ACT_DECRYPT, $urandom, $urandom, 1'b0);

    // Random phases: mostly rekey then a run of decrypts, with stray key actions.
    while (sent_items < TOTAL_ITEMS) begin
      wait_idle();
      if (sent_items + 120 > TOTAL_ITEMS) idle_on = 1'b0;
      random_config();
      if ($urandom_range(0, 4) != 0)
        send_item(ACT_KEY, $urandom, $urandom, 1'($urandom_range(0, 1)));
      len = $urandom_range(30, 70);
      repeat (len) begin
        act = ($urandom_range(0, 24) == 0) ? ACT_KEY : ACT_DECRYPT;
        send_item(act, $urandom, $urandom, ($urandom_range(0, 7) == 0));
      end
    end

    wait_idle();
    repeat (4 * MAX_RND) @(posedge clk_i);

    $display("Covered %0d input transfers (%0d key schedules, %0d unkeyed decrypts), %0d writes",
             sent_items, plain.schedules, plain.unkeyed_hits, reg_writes);
    $display("Checked %0d result transfers, %0d mismatches", plain.checked, plain.mismatches);
    if (plain.mismatches == 0 && plain.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
